// ----- rtl/nga_pkg.sv -----
// shared types, constants and helpers of the n-body gravity accumulator
`timescale 1ns / 1ps
`default_nettype none
package nga_pkg;

    localparam int IDX_W   = 10;
    localparam int POS_W   = 32;
    localparam int ACC_W   = 48;
    localparam int CFG_W   = 32;
    localparam int BCNT_W  = 11;
    localparam int CIDX_W  = 2;
    localparam int MAG_W   = 33;
    localparam int S_W     = 51;
    localparam int ROOT_W  = 32;
    localparam int GM_W    = 64;
    localparam int DEN_W   = 83;
    localparam int PROD_W  = 97;
    localparam int NUM_W   = 103;
    localparam int QUO_W   = 47;

    localparam int MUL_STEPS  = MAG_W;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = QUO_W;

    localparam logic [CIDX_W-1:0] CFG_BODY_COUNT    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GRAVITY_CONST = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_SOFTENING_SQ  = 2'd2;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        MUL_SQ  = 2'd0,
        MUL_GM  = 2'd1,
        MUL_DEN = 2'd2,
        MUL_NUM = 2'd3
    } mul_sel_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic     cap_req;
        logic     mem_wr;
        logic     rd_self;
        logic     cap_self;
        logic     walk_init;
        logic     rd_body;
        logic     cap_body;
        logic     j_inc;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     sqrt_start;
        logic     div_start;
        logic     acc_en;
        axis_t    axis;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic idx_ok;
        logic walk_done;
        logic is_self;
        logic s_zero;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
    } dp_status_t;

    function automatic axis_t next_axis(axis_t a);
        axis_t r;
        case (a)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_Z;
            default: r = AXIS_X;
        endcase
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] abs33(logic signed [MAG_W-1:0] v);
        logic [MAG_W-1:0] r;
        r = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
        return r;
    endfunction

    // clamp a 49-bit sum back to the 48-bit accumulator range
    function automatic logic [ACC_W-1:0] sat_acc(logic [ACC_W:0] s);
        logic [ACC_W-1:0] r;
        if (s[ACC_W] != s[ACC_W-1])
        begin
            r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/nbody_gravity_accumulator.sv -----
// top level of the softened direct-sum gravity accumulator
`timescale 1ns / 1ps
`default_nettype none
// Stores body positions and masses on store requests (command 0) and answers a
// query request (command 1) with the softened gravitational acceleration on the
// named body, summed over bodies 0 to body_count-1. A query walks the bodies
// with one shared 33-step shift-add multiplier used eight times per body, a
// 32-step bit-serial root and a 47-step restoring divider used once per axis;
// the queried body is skipped, a body at zero distance with zero softening
// contributes nothing and skips the rest of its steps, and an axis whose
// quotient overflows skips the divider steps. While a query runs no new request
// is taken; a finished result waits in the output register and stores proceed
// meanwhile. The body memory has no reset: query only bodies that were stored.
// Configuration is written through the cfg channel; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module nbody_gravity_accumulator
    import nga_pkg::*;
#(
    parameter int MAX_BODIES = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // body_index, pos_x, pos_y, pos_z, mass, zero fill
    input  wire logic [143:0]      s_tdata,
    // command
    input  wire logic [0:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // queried_index, acc_x, acc_y, acc_z, zero fill
    output logic [159:0]           m_tdata,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic [BCNT_W-1:0] body_count_reg;
    logic [CFG_W-1:0]  gravity_const_reg;
    logic [CFG_W-1:0]  softening_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_count_reg    <= '0;
            gravity_const_reg <= 32'd65536;
            softening_sq_reg  <= 32'd655;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BODY_COUNT:    body_count_reg    <= cfg_data[BCNT_W-1:0];
                CFG_GRAVITY_CONST: gravity_const_reg <= cfg_data;
                CFG_SOFTENING_SQ:  softening_sq_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic             out_busy;
    logic [IDX_W-1:0] res_index;
    logic [ACC_W-1:0] res_x;
    logic [ACC_W-1:0] res_y;
    logic [ACC_W-1:0] res_z;

    nga_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_busy (out_busy),
        .status   (status),
        .cmd      (cmd)
    );

    nga_dp #(
        .MAX_BODIES (MAX_BODIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (s_tuser[0]),
        .body_index    (s_tdata[9:0]),
        .pos_x         (s_tdata[41:10]),
        .pos_y         (s_tdata[73:42]),
        .pos_z         (s_tdata[105:74]),
        .mass          (s_tdata[137:106]),
        .body_count    (body_count_reg),
        .gravity_const (gravity_const_reg),
        .softening_sq  (softening_sq_reg),
        .cmd           (cmd),
        .status        (status),
        .queried_index (res_index),
        .acc_x         (res_x),
        .acc_y         (res_y),
        .acc_z         (res_z)
    );

    // output register
    logic         m_tvalid_reg;
    logic [159:0] m_tdata_reg;

    assign out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {6'b0, res_z, res_y, res_x, res_index};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/nga_ctrl.sv -----
// sequencer for stores, queries and the per-body interaction steps
`timescale 1ns / 1ps
`default_nettype none
module nga_ctrl
    import nga_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       out_busy,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_DECODE    = 18'h00002,
        S_CAP_SELF  = 18'h00004,
        S_WALK      = 18'h00008,
        S_CAP_BODY  = 18'h00010,
        S_SQ_GO     = 18'h00020,
        S_SQ_WAIT   = 18'h00040,
        S_CHK_S     = 18'h00080,
        S_GM_WAIT   = 18'h00100,
        S_SQRT_WAIT = 18'h00200,
        S_DEN_GO    = 18'h00400,
        S_DEN_WAIT  = 18'h00800,
        S_NUM_GO    = 18'h01000,
        S_NUM_WAIT  = 18'h02000,
        S_DIV_GO    = 18'h04000,
        S_DIV_WAIT  = 18'h08000,
        S_ACC       = 18'h10000,
        S_FINISH    = 18'h20000
    } state_t;

    state_t state_reg, state_next;
    axis_t  axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_req = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!status.is_query)
                begin
                    cmd.mem_wr = 1'b1;
                    state_next = S_IDLE;
                end
                else if (status.idx_ok)
                begin
                    cmd.rd_self = 1'b1;
                    state_next  = S_CAP_SELF;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CAP_SELF:
            begin
                cmd.cap_self  = 1'b1;
                cmd.walk_init = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = S_FINISH;
                end
                else if (status.is_self)
                begin
                    cmd.j_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_body = 1'b1;
                    state_next  = S_CAP_BODY;
                end
            end
            S_CAP_BODY:
            begin
                cmd.cap_body = 1'b1;
                axis_next    = AXIS_X;
                state_next   = S_SQ_GO;
            end
            S_SQ_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SQ;
                state_next    = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (status.mul_done)
                begin
                    axis_next  = next_axis(axis_reg);
                    state_next = (axis_reg == AXIS_Z) ? S_CHK_S : S_SQ_GO;
                end
            end
            S_CHK_S:
            begin
                // a zero denominator contributes nothing
                if (status.s_zero)
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_GM;
                    state_next    = S_GM_WAIT;
                end
            end
            S_GM_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = S_DEN_GO;
                end
            end
            S_DEN_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_DEN;
                state_next    = S_DEN_WAIT;
            end
            S_DEN_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = S_NUM_GO;
                end
            end
            S_NUM_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_NUM;
                state_next    = S_NUM_WAIT;
            end
            S_NUM_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                axis_next  = next_axis(axis_reg);
                if (axis_reg == AXIS_Z)
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_NUM_GO;
                end
            end
            S_FINISH:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_mul_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> (state_reg == S_SQ_WAIT || state_reg == S_GM_WAIT ||
                             state_reg == S_DEN_WAIT || state_reg == S_NUM_WAIT))
        else $error("multiplier finished outside a wait state");

    a_sqrt_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.sqrt_done |-> state_reg == S_SQRT_WAIT)
        else $error("root finished outside its wait state");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_busy)
        else $error("result loaded over a pending result");

endmodule
`default_nettype wire

// ----- rtl/nga_dp.sv -----
// datapath: body memory, shift-add multiplier, root, divider and accumulators
`timescale 1ns / 1ps
`default_nettype none
module nga_dp
    import nga_pkg::*;
#(
    parameter int MAX_BODIES = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              command,
    input  wire logic [IDX_W-1:0]  body_index,
    input  wire logic [POS_W-1:0]  pos_x,
    input  wire logic [POS_W-1:0]  pos_y,
    input  wire logic [POS_W-1:0]  pos_z,
    input  wire logic [POS_W-1:0]  mass,
    input  wire logic [BCNT_W-1:0] body_count,
    input  wire logic [CFG_W-1:0]  gravity_const,
    input  wire logic [CFG_W-1:0]  softening_sq,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    output logic [IDX_W-1:0]       queried_index,
    output logic [ACC_W-1:0]       acc_x,
    output logic [ACC_W-1:0]       acc_y,
    output logic [ACC_W-1:0]       acc_z
);

    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam int WORD_W = 4 * POS_W;

    // request capture
    logic               cmd_q_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WORD_W-1:0]  wdata_reg;
    logic               idx_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            cmd_q_reg <= command;
            idx_reg   <= body_index;
            wdata_reg <= {mass, pos_z, pos_y, pos_x};
        end
    end

    assign idx_ok = 32'(idx_reg) < 32'(MAX_BODIES);

    // walk counter
    logic [CW-1:0] jcnt_reg;
    logic [CW-1:0] nlim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jcnt_reg <= '0;
            nlim_reg <= '0;
        end
        else if (cmd.walk_init)
        begin
            jcnt_reg <= '0;
            nlim_reg <= (32'(body_count) > 32'(MAX_BODIES)) ? CW'(MAX_BODIES)
                                                            : CW'(body_count);
        end
        else if (cmd.j_inc)
        begin
            jcnt_reg <= jcnt_reg + CW'(1);
        end
    end

    // body memory, one word per body: {mass, z, y, x}
    logic [WORD_W-1:0] mem_reg [MAX_BODIES];
    logic [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;

    assign waddr = AW'(idx_reg);
    assign raddr = cmd.rd_self ? AW'(idx_reg) : jcnt_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && idx_ok)
        begin
            mem_reg[waddr] <= wdata_reg;
        end
        if (cmd.rd_self || cmd.rd_body)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    // operands of the current pair
    logic signed [POS_W-1:0] self_reg [3];
    logic [MAG_W-1:0]        mag_reg [3];
    logic                    sign_reg [3];
    logic [POS_W-1:0]        mass_reg;
    logic [S_W-1:0]          s_reg;
    logic [GM_W-1:0]         gm_reg;
    logic [ROOT_W-1:0]       r_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [NUM_W-1:0]        num_reg;
    logic signed [MAG_W-1:0] diff [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = $signed({rdata_reg[a*POS_W+POS_W-1], rdata_reg[a*POS_W +: POS_W]})
                    - $signed({self_reg[a][POS_W-1], self_reg[a]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_self)
        begin
            for (int a = 0; a < 3; a++)
            begin
                self_reg[a] <= rdata_reg[a*POS_W +: POS_W];
            end
        end
        if (cmd.cap_body)
        begin
            for (int a = 0; a < 3; a++)
            begin
                mag_reg[a]  <= abs33(diff[a]);
                sign_reg[a] <= diff[a][MAG_W-1];
            end
            mass_reg <= rdata_reg[3*POS_W +: POS_W];
        end
    end

    // shift-add multiplier, msb of b first
    logic [GM_W-1:0]   mul_a_reg;
    logic [MAG_W-1:0]  mul_b_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [5:0]        mul_cnt_reg;
    logic              mul_busy_reg;
    logic              mul_done_reg;
    mul_sel_t          mul_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= '0;
            mul_sel_reg  <= MUL_SQ;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (cmd.mul_start)
            begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
                mul_sel_reg  <= cmd.mul_sel;
            end
            else if (mul_busy_reg)
            begin
                mul_cnt_reg <= mul_cnt_reg + 6'd1;
                if (mul_cnt_reg == 6'(MUL_STEPS - 1))
                begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            prod_reg <= '0;
            case (cmd.mul_sel)
                MUL_SQ:
                begin
                    mul_a_reg <= GM_W'(mag_reg[cmd.axis]);
                    mul_b_reg <= mag_reg[cmd.axis];
                end
                MUL_GM:
                begin
                    mul_a_reg <= GM_W'(gravity_const);
                    mul_b_reg <= MAG_W'(mass_reg);
                end
                MUL_DEN:
                begin
                    mul_a_reg <= GM_W'(s_reg);
                    mul_b_reg <= MAG_W'(r_reg);
                end
                default:
                begin
                    mul_a_reg <= gm_reg;
                    mul_b_reg <= mag_reg[cmd.axis];
                end
            endcase
        end
        else if (mul_busy_reg)
        begin
            prod_reg  <= {prod_reg[PROD_W-2:0], 1'b0}
                       + (mul_b_reg[MAG_W-1] ? PROD_W'(mul_a_reg) : PROD_W'(0));
            mul_b_reg <= {mul_b_reg[MAG_W-2:0], 1'b0};
        end
    end

    // results of the multiplier land in their operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_body)
        begin
            s_reg <= S_W'(softening_sq);
        end
        else if (mul_done_reg)
        begin
            case (mul_sel_reg)
                MUL_SQ:  s_reg   <= s_reg + S_W'(prod_reg[PROD_W-1:16]);
                MUL_GM:  gm_reg  <= prod_reg[GM_W-1:0];
                MUL_DEN: den_reg <= prod_reg[DEN_W-1:0];
                default: num_reg <= {prod_reg, 6'b0};
            endcase
        end
    end

    // bit-serial integer root of s << 12
    logic [63:0] sq_x_reg;
    logic [63:0] sq_res_reg;
    logic [63:0] sq_bit_reg;
    logic [4:0]  sq_cnt_reg;
    logic        sq_busy_reg;
    logic        sq_done_reg;
    logic [63:0] sq_trial;

    assign sq_trial = sq_res_reg + sq_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_x_reg   <= 64'({s_reg, 12'b0});
            sq_res_reg <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (sq_busy_reg)
        begin
            if (sq_x_reg >= sq_trial)
            begin
                sq_x_reg   <= sq_x_reg - sq_trial;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (sq_done_reg)
        begin
            r_reg <= sq_res_reg[ROOT_W-1:0];
        end
    end

    // restoring divider; a quotient of 2^47 or more is caught up front
    logic [DEN_W-1:0] dv_rem_reg;
    logic [QUO_W-1:0] dv_src_reg;
    logic [QUO_W-1:0] dv_q_reg;
    logic [5:0]       dv_cnt_reg;
    logic             dv_busy_reg;
    logic             dv_done_reg;
    logic             dv_sat_reg;
    logic [DEN_W:0]   dv_trial;
    logic [DEN_W:0]   dv_diff;
    logic             dv_ge;
    logic             dv_over;

    assign dv_trial = {dv_rem_reg, dv_src_reg[QUO_W-1]};
    assign dv_diff  = dv_trial - {1'b0, den_reg};
    assign dv_ge    = dv_trial >= {1'b0, den_reg};
    assign dv_over  = DEN_W'(num_reg[NUM_W-1:QUO_W]) >= den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_done_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else
        begin
            dv_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dv_cnt_reg <= '0;
                if (dv_over)
                begin
                    dv_done_reg <= 1'b1;
                end
                else
                begin
                    dv_busy_reg <= 1'b1;
                end
            end
            else if (dv_busy_reg)
            begin
                dv_cnt_reg <= dv_cnt_reg + 6'd1;
                if (dv_cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    dv_busy_reg <= 1'b0;
                    dv_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dv_sat_reg <= dv_over;
            dv_rem_reg <= DEN_W'(num_reg[NUM_W-1:QUO_W]);
            dv_src_reg <= num_reg[QUO_W-1:0];
            dv_q_reg   <= '0;
        end
        else if (dv_busy_reg)
        begin
            dv_rem_reg <= dv_ge ? dv_diff[DEN_W-1:0] : dv_trial[DEN_W-1:0];
            dv_q_reg   <= {dv_q_reg[QUO_W-2:0], dv_ge};
            dv_src_reg <= {dv_src_reg[QUO_W-2:0], 1'b0};
        end
    end

    // signed saturating accumulation
    logic [ACC_W-1:0]        acc_reg [3];
    logic [QUO_W-1:0]        term_mag;
    logic signed [ACC_W:0]   term;
    logic signed [ACC_W:0]   acc_sum;

    assign term_mag = dv_sat_reg ? {QUO_W{1'b1}} : dv_q_reg;
    assign term     = sign_reg[cmd.axis] ? -$signed({2'b00, term_mag})
                                         : $signed({2'b00, term_mag});
    assign acc_sum  = $signed({acc_reg[cmd.axis][ACC_W-1], acc_reg[cmd.axis]}) + term;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= '0;
            end
        end
        else if (cmd.acc_en)
        begin
            acc_reg[cmd.axis] <= sat_acc(acc_sum);
        end
    end

    assign status.is_query  = (cmd_q_reg == CMD_QUERY);
    assign status.idx_ok    = idx_ok;
    assign status.walk_done = jcnt_reg >= nlim_reg;
    assign status.is_self   = 32'(jcnt_reg) == 32'(idx_reg);
    assign status.s_zero    = (s_reg == '0);
    assign status.mul_done  = mul_done_reg;
    assign status.sqrt_done = sq_done_reg;
    assign status.div_done  = dv_done_reg;

    assign queried_index = idx_reg;
    assign acc_x         = acc_reg[0];
    assign acc_y         = acc_reg[1];
    assign acc_z         = acc_reg[2];

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for the softened direct-sum gravity accumulator
`timescale 1ns / 1ps
module tb_top;
    import nga_pkg::*;

    localparam int NB = 1024;
    localparam longint ACC_TOP = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_BOT = -64'sh8000_0000_0000;

    typedef struct {
        logic            cmd;
        logic [IDX_W-1:0] idx;
        logic [31:0]     px;
        logic [31:0]     py;
        logic [31:0]     pz;
        logic [31:0]     mass;
    } body_req_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [ACC_W-1:0] ax;
        logic [ACC_W-1:0] ay;
        logic [ACC_W-1:0] az;
    } accel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [143:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    nbody_gravity_accumulator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the block state
    logic [31:0] mem_x [NB];
    logic [31:0] mem_y [NB];
    logic [31:0] mem_z [NB];
    logic [31:0] mem_m [NB];
    logic [10:0] sh_count = 11'd0;
    logic [31:0] sh_grav = 32'd65536;
    logic [31:0] sh_soft = 32'd655;

    body_req_t pending_reqs[$];
    accel_t    accel_due[$];
    int n_pushed = 0;
    int n_taken = 0;
    int n_err = 0;
    logic in_acc = 1'b0;
    int src_gap = 0;
    int rcv_gap = 0;
    bit no_idle = 0;
    bit long_hold = 0;
    bit written [NB];
    int written_list[$];

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x = v;
        res = 0;
        for (int i = 0; i < 32; i++)
        begin
            b = 64'd1 << (62 - 2 * i);
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    function automatic accel_t predict_accel(logic [IDX_W-1:0] qi);
        accel_t a;
        longint acc [3];
        longint d [3];
        longint t;
        logic [63:0] mag [3];
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] gm;
        logic [127:0] den;
        logic [127:0] q;
        int n;
        acc = '{0, 0, 0};
        n = (sh_count > NB) ? NB : sh_count;
        for (int j = 0; j < n; j++)
        begin
            if (j == qi)
                continue;
            d[0] = longint'($signed(mem_x[j])) - longint'($signed(mem_x[qi]));
            d[1] = longint'($signed(mem_y[j])) - longint'($signed(mem_y[qi]));
            d[2] = longint'($signed(mem_z[j])) - longint'($signed(mem_z[qi]));
            s = 64'(sh_soft);
            for (int k = 0; k < 3; k++)
            begin
                mag[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
                s = s + ((mag[k] * mag[k]) >> 16);
            end
            r = int_root(s << 12);
            den = 128'(s) * 128'(r);
            if (den == 0)
                continue;
            gm = 64'(sh_grav) * 64'(mem_m[j]);
            for (int k = 0; k < 3; k++)
            begin
                q = ((128'(gm) * 128'(mag[k])) << 6) / den;
                t = (q > 128'(ACC_TOP)) ? ACC_TOP : longint'(q[63:0]);
                if (d[k] < 0)
                    t = -t;
                acc[k] = acc[k] + t;
                if (acc[k] > ACC_TOP)
                    acc[k] = ACC_TOP;
                if (acc[k] < ACC_BOT)
                    acc[k] = ACC_BOT;
            end
        end
        a.idx = qi;
        a.ax = acc[0][ACC_W-1:0];
        a.ay = acc[1][ACC_W-1:0];
        a.az = acc[2][ACC_W-1:0];
        return a;
    endfunction

    // request side: update the shadow on every accepted store, predict on every accepted query
    always @(posedge clk)
    begin
        logic [IDX_W-1:0] i;
        in_acc <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            n_taken++;
            i = s_tdata[9:0];
            if (s_tuser[0] == CMD_STORE)
            begin
                mem_x[i] = s_tdata[41:10];
                mem_y[i] = s_tdata[73:42];
                mem_z[i] = s_tdata[105:74];
                mem_m[i] = s_tdata[137:106];
            end
            else
            begin
                accel_due = {accel_due, predict_accel(i)};
            end
        end
    end

    always @(posedge clk)
    begin
        accel_t e;
        if (m_tvalid && m_tready)
        begin
            if (accel_due.size() == 0)
            begin
                $error("result with nothing outstanding, index %0d", m_tdata[9:0]);
                n_err++;
            end
            else
            begin
                e = accel_due.pop_front();
                if (m_tdata[9:0] !== e.idx)
                begin
                    $error("queried_index expected %0d got %0d", e.idx, m_tdata[9:0]);
                    n_err++;
                end
                if (m_tdata[57:10] !== e.ax)
                begin
                    $error("acc_x expected %h got %h", e.ax, m_tdata[57:10]);
                    n_err++;
                end
                if (m_tdata[105:58] !== e.ay)
                begin
                    $error("acc_y expected %h got %h", e.ay, m_tdata[105:58]);
                    n_err++;
                end
                if (m_tdata[153:106] !== e.az)
                begin
                    $error("acc_z expected %h got %h", e.az, m_tdata[153:106]);
                    n_err++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        body_req_t b;
        if (s_tvalid && !in_acc)
        begin
            // request still waiting, hold it
        end
        else if (src_gap > 0)
        begin
            src_gap--;
            s_tvalid <= 1'b0;
        end
        else if (pending_reqs.size() > 0)
        begin
            b = pending_reqs.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= b.cmd;
            s_tdata <= {6'd0, b.mass, b.pz, b.py, b.px, b.idx};
            if (!no_idle && $urandom_range(0, 9) == 0)
                src_gap = $urandom_range(1, 18);
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (long_hold)
        begin
            m_tready <= 1'b0;
        end
        else if (rcv_gap > 0)
        begin
            rcv_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0)
                rcv_gap = $urandom_range(1, 18);
        end
    end

    // long receiver stall while requests keep coming
    initial
    begin
        wait (n_taken >= 70);
        long_hold = 1;
        repeat (6000) @(posedge clk);
        long_hold = 0;
    end

    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic push_req(logic c, int i, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] m);
        body_req_t b;
        b.cmd = c;
        b.idx = i[IDX_W-1:0];
        b.px = x;
        b.py = y;
        b.pz = z;
        b.mass = m;
        if (c == CMD_STORE && !written[i])
        begin
            written[i] = 1;
            written_list = {written_list, i};
        end
        pending_reqs = {pending_reqs, b};
        n_pushed++;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (!(n_taken == n_pushed && accel_due.size() == 0))
            @(posedge clk);
        // a last store may still be in flight
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] ri, logic [31:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (ri)
            CFG_BODY_COUNT:    sh_count = v[10:0];
            CFG_GRAVITY_CONST: sh_grav = v;
            default:           sh_soft = v;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] c, logic [31:0] g, logic [31:0] s);
        wait_idle();
        write_reg(CFG_BODY_COUNT, c);
        write_reg(CFG_GRAVITY_CONST, g);
        write_reg(CFG_SOFTENING_SQ, s);
    endtask

    function automatic logic [31:0] rand_pos();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = $urandom();
            default: v = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_mass();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'hFFFF_FFFF;
            1: v = 32'd0;
            2: v = $urandom();
            default: v = $urandom_range(0, 32'h0004_0000);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = a;
            1: v = b;
            2: v = c;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    initial
    begin
        int qi;
        logic [31:0] s_val;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, coincident bodies, walk below the queried index
        push_req(CMD_STORE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
        push_req(CMD_STORE, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(CMD_STORE, 2, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
        push_req(CMD_STORE, 3, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_8000);
        push_req(CMD_STORE, 4, 32'd0, 32'd0, 32'd0, 32'd0);
        push_req(CMD_STORE, 5, 32'hFFFF_0000, 32'h0000_8000, 32'h0004_0000, 32'h0010_0000);
        push_req(CMD_STORE, 1023, 32'h1234_5678, 32'hEDCB_A987, 32'h5555_AAAA, 32'hAAAA_5555);
        for (int i = 6; i < 16; i++)
            push_req(CMD_STORE, i, rand_pos(), rand_pos(), rand_pos(), rand_mass());
        push_req(CMD_QUERY, 3, 0, 0, 0, 0);
        push_req(CMD_QUERY, 1023, 0, 0, 0, 0);
        set_all(8, 32'd65536, 32'd655);
        push_req(CMD_QUERY, 2, 0, 0, 0, 0);
        push_req(CMD_QUERY, 0, 0, 0, 0, 0);
        push_req(CMD_QUERY, 12, 0, 0, 0, 0);
        set_all(3, 32'hFFFF_FFFF, 32'd1);
        push_req(CMD_QUERY, 0, 0, 0, 0, 0);
        push_req(CMD_QUERY, 3, 0, 0, 0, 0);
        set_all(1, 32'd0, 32'hFFFF_FFFF);
        push_req(CMD_QUERY, 0, 0, 0, 0, 0);
        push_req(CMD_QUERY, 4, 0, 0, 0, 0);

        // random phases with small walks
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
            begin
                // last phase runs without idling
                wait_idle();
                no_idle = 1;
            end
            s_val = pick(32'd1, 32'hFFFF_FFFF, 32'd655);
            if (s_val == 0)
                s_val = 1;
            set_all($urandom_range(0, 6), pick(32'd0, 32'hFFFF_FFFF, 32'd65536), s_val);
            for (int k = 0; k < 70; k++)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    qi = written_list[$urandom_range(0, written_list.size() - 1)];
                    push_req(CMD_QUERY, qi, $urandom(), $urandom(), $urandom(), $urandom());
                end
                else
                begin
                    qi = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, NB - 1);
                    push_req(CMD_STORE, qi, rand_pos(), rand_pos(), rand_pos(), rand_mass());
                end
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (n_err == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/nga_pkg.sv
rtl/nga_ctrl.sv
rtl/nga_dp.sv
rtl/nbody_gravity_accumulator.sv
bench/tb_top.sv
